// ===== src/decimal_text_to_scaled_integer_top_defines.svh =====
// Assertion macros shared by the checker of the decimal text parser.
// Depends on nothing; expects clk and rst in the scope of use.
`ifndef DECIMAL_TEXT_TO_SCALED_INTEGER_TOP_DEFINES_SVH
`define DECIMAL_TEXT_TO_SCALED_INTEGER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DTSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define DTSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dtsi_pkg.sv =====
// Shared types and constants of the decimal text parser.
// No dependencies; used by the front, back and top level.
package dtsi_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_NUM  = 3'd1,
    ST_NO_FRAC  = 3'd2,
    ST_TOO_MANY = 3'd3,
    ST_BELOW    = 3'd4,
    ST_ABOVE    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_MIN_VALUE = 2'd0,
    REG_MAX_VALUE = 2'd1,
    REG_SCALE     = 2'd2,
    REG_MAX_SCALE = 2'd3
  } reg_idx_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic signed [31:0] MIN_VALUE_RST = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_VALUE_RST = 32'sh7FFF_FFFF;
  localparam logic [3:0]         SCALE_RST     = 4'd3;
  localparam logic [7:0]         MAX_SCALE_RST = 8'd5;
  localparam logic [7:0]         FRAC_CNT_MAX  = 8'hFF;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [3:0]         scale;
    logic [7:0]         max_scale;
  } cfg_t;

  // one finished number handed from the front to the back
  typedef struct packed {
    logic       is_err;
    status_t    code;
    logic       neg;
    logic [7:0] frac_cnt;
  } job_t;

endpackage

// ===== src/dtsi_fifo.sv =====
// Small flop-based queue with registered pointers and a fill count.
// No package dependencies; used for the job and result queues.
module dtsi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_data;
  end

endmodule

// ===== src/dtsi_front.sv =====
// Character front end: parses sign, integer and fraction digits one per cycle
// when fire is high. Uses dtsi_pkg; hands each finished number to the job queue.
module dtsi_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            ch,
  input  dtsi_pkg::cfg_t        cfg,
  output logic                  job_push,
  output dtsi_pkg::job_t        job,
  output logic [VALUE_BITS-1:0] job_acc
);

  typedef enum logic [4:0] {
    P_START = 5'b00001,
    P_SIGN  = 5'b00010,
    P_INT   = 5'b00100,
    P_DOT   = 5'b01000,
    P_FRAC  = 5'b10000
  } phase_t;

  phase_t                phase, phase_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [7:0]            frac_cnt, frac_cnt_next;
  logic                  neg, neg_next;

  logic                  is_dig;
  logic [3:0]            dig;
  logic [VALUE_BITS-1:0] acc_mac;
  logic [7:0]            scale_ext;
  logic [7:0]            ch_off;

  assign is_dig    = (ch >= dtsi_pkg::CH_ZERO) && (ch <= dtsi_pkg::CH_NINE);
  assign ch_off    = ch - dtsi_pkg::CH_ZERO;
  assign dig       = ch_off[3:0];
  assign acc_mac   = (acc << 3) + (acc << 1) + VALUE_BITS'(dig);
  assign scale_ext = 8'(cfg.scale);

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    frac_cnt_next = frac_cnt;
    neg_next      = neg;
    job_push      = 1'b0;
    job.is_err    = 1'b0;
    job.code      = dtsi_pkg::ST_OK;
    job.neg       = neg;
    job.frac_cnt  = frac_cnt;
    job_acc       = acc;
    case (phase)
      P_SIGN, P_INT: begin
        if (is_dig) begin
          acc_next   = acc_mac;
          phase_next = P_INT;
        end else if (ch == dtsi_pkg::CH_DOT) begin
          phase_next = P_DOT;
        end else begin
          job_push = 1'b1;
          if (phase == P_SIGN) begin
            job.is_err = 1'b1;
            job.code   = dtsi_pkg::ST_NOT_NUM;
          end
        end
      end
      P_DOT, P_FRAC: begin
        if (is_dig) begin
          if (frac_cnt < scale_ext) begin
            acc_next = acc_mac;
          end else if (frac_cnt == scale_ext && ch >= dtsi_pkg::CH_FIVE) begin
            acc_next = acc + VALUE_BITS'(1);
          end
          if (frac_cnt != dtsi_pkg::FRAC_CNT_MAX) frac_cnt_next = frac_cnt + 8'd1;
          phase_next = P_FRAC;
        end else begin
          job_push = 1'b1;
          if (phase == P_DOT) begin
            job.is_err = 1'b1;
            job.code   = dtsi_pkg::ST_NO_FRAC;
          end
        end
      end
      default: begin
        // start of a number, also any stray phase code
        acc_next      = '0;
        frac_cnt_next = '0;
        neg_next      = 1'b0;
        phase_next    = P_START;
        if (ch == dtsi_pkg::CH_MINUS) begin
          neg_next   = 1'b1;
          phase_next = P_SIGN;
        end else if (is_dig) begin
          acc_next   = VALUE_BITS'(dig);
          phase_next = P_INT;
        end else if (ch == dtsi_pkg::CH_DOT) begin
          phase_next = P_DOT;
        end else begin
          job_push   = 1'b1;
          job.is_err = 1'b1;
          job.code   = dtsi_pkg::ST_NOT_NUM;
        end
      end
    endcase
    // drop the number once it has been handed off
    if (job_push) begin
      phase_next    = P_START;
      acc_next      = '0;
      frac_cnt_next = '0;
      neg_next      = 1'b0;
    end
    if (!fire) job_push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= P_START;
      acc      <= '0;
      frac_cnt <= '0;
      neg      <= 1'b0;
    end else if (fire) begin
      phase    <= phase_next;
      acc      <= acc_next;
      frac_cnt <= frac_cnt_next;
      neg      <= neg_next;
    end
  end

endmodule

// ===== src/dtsi_back.sv =====
// Back end: pads missing fraction digits, applies sign, checks the range.
// Depends on dtsi_pkg; reads the job queue and fills the result queue.
module dtsi_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dtsi_pkg::cfg_t        cfg,
  input  logic                  job_valid,
  input  dtsi_pkg::job_t        job,
  input  logic [VALUE_BITS-1:0] job_acc,
  output logic                  job_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output logic signed [31:0]    res_value,
  output dtsi_pkg::status_t     res_status
);

  localparam int CMPW = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_PAD   = 4'b0010,
    B_CHECK = 4'b0100,
    B_EMIT  = 4'b1000
  } bstate_t;

  bstate_t               state, state_next;
  logic [VALUE_BITS-1:0] v;
  logic [7:0]            n;
  logic                  neg;

  logic signed [VALUE_BITS-1:0] v_s;
  logic signed [CMPW-1:0]       v_cmp;
  logic [CMPW-1:0]              v_zx;
  logic signed [CMPW-1:0]       min_cmp;
  logic signed [CMPW-1:0]       max_cmp;

  assign v_s     = v;
  assign v_cmp   = CMPW'(v_s);
  assign v_zx    = CMPW'(v);
  assign min_cmp = CMPW'(cfg.min_value);
  assign max_cmp = CMPW'(cfg.max_value);

  assign job_pop  = (state == B_IDLE) && job_valid;
  assign res_push = (state == B_EMIT) && !res_full;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          if (job.is_err || job.frac_cnt > cfg.max_scale) state_next = B_EMIT;
          else state_next = B_PAD;
        end
      end
      B_PAD: begin
        if (n >= 8'(cfg.scale)) state_next = B_CHECK;
      end
      B_CHECK: state_next = B_EMIT;
      B_EMIT: begin
        if (!res_full) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        v   <= job_acc;
        n   <= job.frac_cnt;
        neg <= job.neg;
        res_value <= '0;
        if (job.is_err) res_status <= job.code;
        else            res_status <= dtsi_pkg::ST_TOO_MANY;
      end
      B_PAD: begin
        // one times-ten per cycle, then the sign on the way out
        if (n < 8'(cfg.scale)) begin
          v <= (v << 3) + (v << 1);
          n <= n + 8'd1;
        end else if (neg) begin
          v <= '0 - v;
        end
      end
      B_CHECK: begin
        res_value <= v_zx[31:0];
        if (v_cmp < min_cmp)      res_status <= dtsi_pkg::ST_BELOW;
        else if (v_cmp > max_cmp) res_status <= dtsi_pkg::ST_ABOVE;
        else                      res_status <= dtsi_pkg::ST_OK;
      end
      default: begin
        v <= v;
      end
    endcase
  end

endmodule

// ===== src/decimal_text_to_scaled_integer_top.sv =====
// Top level of the decimal text parser: config registers, front, back, queues.
// Depends on dtsi_pkg, dtsi_fifo, dtsi_front and dtsi_back.
//
// Takes one ASCII character per cycle whenever full is low; full rises only
// when JOB_DEPTH finished numbers are waiting for the back end. Each finished
// number is padded with one multiply-by-ten per missing fraction digit (scale
// minus fraction digits seen, when positive), then range checked; format
// errors skip both. The padding multiply-by-ten loop in the back end is
// what sets the result rate; the job queue absorbs bursts of short numbers and
// the result queue of OUT_DEPTH entries lets the consumer stall on its own.
// Results are read queue style: value and status are valid while empty is low.
module decimal_text_to_scaled_integer_top #(
  parameter int VALUE_BITS = 32,
  parameter int JOB_DEPTH  = 4,
  parameter int OUT_DEPTH  = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         ch,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] value,
  output logic [2:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int JOBW = $bits(dtsi_pkg::job_t) + VALUE_BITS;
  localparam int RESW = 32 + $bits(dtsi_pkg::status_t);

  dtsi_pkg::cfg_t        cfg;
  logic                  fire;
  logic                  job_push;
  dtsi_pkg::job_t        job_in;
  logic [VALUE_BITS-1:0] acc_in;
  logic                  job_full;
  logic                  job_empty;
  logic                  job_pop;
  logic [JOBW-1:0]       job_rd;
  dtsi_pkg::job_t        job_out;
  logic [VALUE_BITS-1:0] acc_out;
  logic                  res_full;
  logic                  res_push;
  logic signed [31:0]    res_value;
  dtsi_pkg::status_t     res_status;
  logic [RESW-1:0]       res_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_value <= dtsi_pkg::MIN_VALUE_RST;
      cfg.max_value <= dtsi_pkg::MAX_VALUE_RST;
      cfg.scale     <= dtsi_pkg::SCALE_RST;
      cfg.max_scale <= dtsi_pkg::MAX_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (dtsi_pkg::reg_idx_t'(cfg_index))
        dtsi_pkg::REG_MIN_VALUE: cfg.min_value <= cfg_data;
        dtsi_pkg::REG_MAX_VALUE: cfg.max_value <= cfg_data;
        dtsi_pkg::REG_SCALE:     cfg.scale     <= cfg_data[3:0];
        dtsi_pkg::REG_MAX_SCALE: cfg.max_scale <= cfg_data[7:0];
        default:                 cfg <= cfg;
      endcase
    end
  end

  assign full = job_full;
  assign fire = push && !job_full;

  dtsi_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .ch       (ch),
    .cfg      (cfg),
    .job_push (job_push),
    .job      (job_in),
    .job_acc  (acc_in)
  );

  dtsi_fifo #(.WIDTH(JOBW), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .wr_data ({job_in, acc_in}),
    .full    (job_full),
    .pop     (job_pop),
    .rd_data (job_rd),
    .empty   (job_empty)
  );

  assign {job_out, acc_out} = job_rd;

  dtsi_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job_valid  (!job_empty),
    .job        (job_out),
    .job_acc    (acc_out),
    .job_pop    (job_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_value  (res_value),
    .res_status (res_status)
  );

  dtsi_fifo #(.WIDTH(RESW), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data ({res_value, res_status}),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign value  = res_rd[RESW-1:3];
  assign status = res_rd[2:0];

endmodule

// ===== src/dtsi_checker.sv =====
// Port-level checker for the decimal text parser, bound to the top level.
// Depends on decimal_text_to_scaled_integer_top_defines.svh and dtsi_pkg.
`include "decimal_text_to_scaled_integer_top_defines.svh"

module dtsi_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] value,
  input logic [2:0]         status,
  input logic               cfg_ready
);

  logic fmt_err;

  assign fmt_err = (status == dtsi_pkg::ST_NOT_NUM) || (status == dtsi_pkg::ST_NO_FRAC) ||
                   (status == dtsi_pkg::ST_TOO_MANY);

  `DTSI_ASSERT_NOW(a_out_of_reset, $past(rst), empty && !full && cfg_ready, "not idle after reset")

  `DTSI_ASSERT_NOW(a_status_code, !empty, status <= dtsi_pkg::ST_ABOVE, "undefined status code")

  `DTSI_ASSERT_NOW(a_error_zero, !empty && fmt_err, value == 32'sd0, "format error with value")

  `DTSI_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable({value, status}), "beat moved")

endmodule

bind decimal_text_to_scaled_integer_top dtsi_checker u_dtsi_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .value     (value),
  .status    (status),
  .cfg_ready (cfg_ready)
);
